@@ sv/sortpq_pkg.sv @@
// sortpq_pkg: shared types and codes for the sorted priority queue
`timescale 1ns / 1ps

package sortpq_pkg;

	localparam int STATUS_BITS = 2;

	typedef logic [STATUS_BITS-1:0] status_t;

	// result status codes
	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic    load;     // capture the accepted item
		logic    execute;  // load the result register
		logic    update;   // change the stored entries and the count
		status_t code;     // status of the item being executed
	} sortpq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op_remove;
		logic full;
		logic empty;
	} sortpq_flags_t;

endpackage

@@ sv/sorted_priority_queue.sv @@
// sorted_priority_queue: top level joining the controller and the entry datapath
`timescale 1ns / 1ps
//
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------------
// item     | item_valid / item_ready    | operation, item_value, item_priority
// result   | result_valid / result_ready| status, removed_value, entry_count
//
// an item is first accepted; it then runs the parallel
// compare-and-shift over the cell row and loads the result register
// execution waits while the result register holds an item not yet taken,
// and no new item is accepted during that wait
// reset clears the entry count and the handshake state only; cells are
// never read above the count, so no clearing pass is needed
// insert places the entry behind all of lower or equal priority number,
// remove shifts the row up one cell

module sorted_priority_queue import sortpq_pkg::*; #(
	parameter int DEPTH         = 16,
	parameter int PRIORITY_BITS = 8,
	parameter int VALUE_BITS    = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic                           operation,
	input  logic signed [VALUE_BITS-1:0]   item_value,
	input  logic [PRIORITY_BITS-1:0]       item_priority,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [STATUS_BITS-1:0]         status,
	output logic signed [VALUE_BITS-1:0]   removed_value,
	output logic [$clog2(DEPTH + 1)-1:0]   entry_count
);

	// command and status between the two halves
	sortpq_cmd_t   cmd;
	sortpq_flags_t flags;

	sortpq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.flags        (flags),
		.cmd          (cmd)
	);

	// sorted cell row, head at cell zero
	sortpq_datapath #(
		.DEPTH         (DEPTH),
		.PRIORITY_BITS (PRIORITY_BITS),
		.VALUE_BITS    (VALUE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.operation     (operation),
		.item_value    (item_value),
		.item_priority (item_priority),
		.cmd           (cmd),
		.flags         (flags),
		.status        (status),
		.removed_value (removed_value),
		.entry_count   (entry_count)
	);

endmodule

@@ sv/sortpq_datapath.sv @@
// sortpq_datapath: row of sorted entry cells, entry count and result register
`timescale 1ns / 1ps

module sortpq_datapath import sortpq_pkg::*; #(
	parameter int DEPTH         = 16,
	parameter int PRIORITY_BITS = 8,
	parameter int VALUE_BITS    = 32,
	localparam int CW           = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     operation,
	input  logic [VALUE_BITS-1:0]    item_value,
	input  logic [PRIORITY_BITS-1:0] item_priority,
	input  sortpq_cmd_t              cmd,
	output sortpq_flags_t            flags,
	output status_t                  status,
	output logic [VALUE_BITS-1:0]    removed_value,
	output logic [CW-1:0]            entry_count
);

	logic                     op_q;
	logic [VALUE_BITS-1:0]    val_q;
	logic [PRIORITY_BITS-1:0] pri_q;

	logic [VALUE_BITS-1:0]    val_cells_q [DEPTH];
	logic [PRIORITY_BITS-1:0] pri_cells_q [DEPTH];
	logic [CW-1:0]            count_q;

	status_t                  status_q;
	logic [VALUE_BITS-1:0]    removed_q;

	logic [DEPTH-1:0]         gt;

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			val_q <= item_value;
			pri_q <= item_priority;
		end
	end

	// held cells whose priority number is strictly above the new one; the row is sorted
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CW'(i) < count_q) && (pri_cells_q[i] > pri_q);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic shift_in;
		logic take_new;

		if (g == 0) begin : g_first
			assign shift_in = 1'b0;
		end else begin : g_rest
			assign shift_in = gt[g-1];
		end

		assign take_new = gt[g] || (CW'(g) == count_q);

		always_ff @(posedge clk) begin
			if (cmd.update) begin
				if (op_q == OP_REMOVE) begin
					if (g < DEPTH - 1) begin
						val_cells_q[g] <= val_cells_q[(g < DEPTH - 1) ? g + 1 : g];
						pri_cells_q[g] <= pri_cells_q[(g < DEPTH - 1) ? g + 1 : g];
					end
				end else if (shift_in) begin
					val_cells_q[g] <= val_cells_q[(g > 0) ? g - 1 : g];
					pri_cells_q[g] <= pri_cells_q[(g > 0) ? g - 1 : g];
				end else if (take_new) begin
					val_cells_q[g] <= val_q;
					pri_cells_q[g] <= pri_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.update) begin
			if (op_q == OP_REMOVE) begin
				count_q <= count_q - CW'(1);
			end else begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q  <= cmd.code;
			removed_q <= (cmd.update && op_q == OP_REMOVE) ? val_cells_q[0] : '0;
		end
	end

	assign flags.op_remove = (op_q == OP_REMOVE);
	assign flags.full      = (count_q == CW'(DEPTH));
	assign flags.empty     = (count_q == '0);

	assign status        = status_q;
	assign removed_value = removed_q;
	assign entry_count   = count_q;

endmodule

@@ sv/sortpq_ctrl.sv @@
// sortpq_ctrl: handshake and sequencing state machine
`timescale 1ns / 1ps

module sortpq_ctrl import sortpq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	output logic          result_valid,
	input  logic          result_ready,
	input  sortpq_flags_t flags,
	output sortpq_cmd_t   cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t  state_q;
	logic    result_valid_q;
	logic    slot_free;
	status_t code;

	assign slot_free = !result_valid_q || result_ready;

	always_comb begin
		if (flags.op_remove) begin
			code = flags.empty ? ST_EMPTY : ST_DONE;
		end else begin
			code = flags.full ? ST_FULL : ST_DONE;
		end
	end

	assign item_ready  = (state_q == S_IDLE);
	assign cmd.load    = item_valid && item_ready;
	assign cmd.execute = (state_q == S_EXEC) && slot_free;
	assign cmd.update  = cmd.execute && (code == ST_DONE);
	assign cmd.code    = code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.execute) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

	a_exec_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> (!result_valid_q || result_ready))
		else $error("result register overwritten while still held");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (!item_ready && !cmd.load))
		else $error("second item accepted before the first was executed");

	a_exec_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> result_valid)
		else $error("executed item gave no result");

	a_update_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> (flags.op_remove ? !flags.empty : !flags.full))
		else $error("entries changed on a full insert or empty remove");

endmodule
